[rtl/core/framebuffer_shape_raster_assert.svh]
// Assertion macros shared by the shape raster RTL.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef FRAMEBUFFER_SHAPE_RASTER_ASSERT_SVH
`define FRAMEBUFFER_SHAPE_RASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fsr_pkg.sv]
// Shared types, screen constants and helpers for the shape raster.
// Depends on nothing.
`default_nettype none
package fsr_pkg;
	localparam int SCREEN_W = 128;
	localparam int SCREEN_H = 128;
	localparam int ROW_BYTES = (SCREEN_W + 1) / 2;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;
	localparam int AW = $clog2(STORE_BYTES > 1 ? STORE_BYTES : 2);
	localparam int XW = $clog2(SCREEN_W);
	localparam int YW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;

	typedef enum logic [2:0] {
		ACT_CLEAR = 3'd0,
		ACT_READ  = 3'd1,
		ACT_RECT  = 3'd2,
		ACT_FILL  = 3'd3,
		ACT_CIRC  = 3'd4,
		ACT_DISC  = 3'd5
	} act_t;

	typedef struct packed {
		act_t               op;
		logic [XW-1:0]      x0;
		logic [YW-1:0]      y0;
		logic [XW-1:0]      x1;
		logic [YW-1:0]      y1;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [7:0]         r;
		logic [15:0]        rsq;
		logic [3:0]         color;
		logic               on_scr;
	} cmd_t;

	function automatic logic on_screen(input logic signed [17:0] x,
		input logic signed [17:0] y);
		return (x >= 0) && (x < 18'(SCREEN_W)) && (y >= 0) && (y < 18'(SCREEN_H));
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		return AW'(int'(y) * ROW_BYTES + int'(x >> 1));
	endfunction
endpackage
`default_nettype wire

[rtl/core/fsr_cmd_fifo.sv]
// Two-entry command queue between the classifier and the raster engine.
// Depends on fsr_pkg.
`default_nettype none
module fsr_cmd_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire fsr_pkg::cmd_t wr_cmd,
	output logic              is_full,
	input  wire logic         rd_en,
	output fsr_pkg::cmd_t     rd_cmd,
	output logic              is_empty
);
	import fsr_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign is_full  = (cnt_q == 2'd2);
	assign is_empty = (cnt_q == 2'd0);
	assign rd_cmd   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) ent_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule
`default_nettype wire

[rtl/core/fsr_front.sv]
// Command classifier: clamps corners, squares the radius, drops no-op commands.
// Depends on fsr_pkg.
`default_nettype none
module fsr_front (
	input  wire logic               [2:0] action,
	input  wire logic              [15:0] corner_left,
	input  wire logic              [15:0] corner_top,
	input  wire logic              [15:0] corner_right,
	input  wire logic              [15:0] corner_bottom,
	input  wire logic signed       [15:0] center_x,
	input  wire logic signed       [15:0] center_y,
	input  wire logic               [7:0] radius,
	input  wire logic               [3:0] color,
	output fsr_pkg::cmd_t                 cmd,
	output logic                          keep
);
	import fsr_pkg::*;

	logic [XW-1:0] x0, x1;
	logic [YW-1:0] y0, y1;
	logic          ctr_on;

	always_comb begin
		x0 = (corner_left   > 16'(SCREEN_W - 1)) ? XW'(SCREEN_W - 1) : corner_left[XW-1:0];
		x1 = (corner_right  > 16'(SCREEN_W - 1)) ? XW'(SCREEN_W - 1) : corner_right[XW-1:0];
		y0 = (corner_top    > 16'(SCREEN_H - 1)) ? YW'(SCREEN_H - 1) : corner_top[YW-1:0];
		y1 = (corner_bottom > 16'(SCREEN_H - 1)) ? YW'(SCREEN_H - 1) : corner_bottom[YW-1:0];
		ctr_on = on_screen(18'(center_x), 18'(center_y));

		cmd.op     = act_t'(action);
		cmd.x0     = x0;
		cmd.y0     = y0;
		cmd.x1     = x1;
		cmd.y1     = y1;
		cmd.cx     = center_x;
		cmd.cy     = center_y;
		cmd.r      = radius;
		cmd.rsq    = 16'(radius) * 16'(radius);
		cmd.color  = color;
		cmd.on_scr = ctr_on;

		unique case (action)
			ACT_CLEAR, ACT_READ: keep = 1'b1;
			ACT_RECT, ACT_FILL:  keep = (x0 <= x1) && (y0 <= y1);
			ACT_CIRC:            keep = (radius != 8'd0);
			ACT_DISC:            keep = ctr_on;
			default:             keep = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/fsr_engine.sv]
// Raster engine: walks shapes and does read-modify-write on the packed store.
// Depends on fsr_pkg and framebuffer_shape_raster_assert.svh.
`default_nettype none
module fsr_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_empty,
	input  wire fsr_pkg::cmd_t cmd_in,
	output logic            cmd_pop,
	output logic            init_busy,
	input  wire logic       res_full,
	output logic            res_push,
	output logic      [3:0] res_data
);
	import fsr_pkg::*;
	`include "framebuffer_shape_raster_assert.svh"

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RECT, S_COUT, S_CFILL, S_RD, S_WR
	} state_t;

	state_t               state_q, ret_q;
	cmd_t                 cmd_q;
	logic [AW-1:0]        addr_q, clr_q;
	logic                 odd_q, rd_q, rd_off_q, init_q;
	logic [7:0]           rdata_q;
	logic [XW-1:0]        rx_q;
	logic [YW-1:0]        ry_q;
	logic signed [9:0]    ox_q, oy_q, dx_q, dy_q;
	logic signed [12:0]   tx_q, ty_q, err_q;
	logic [2:0]           pt_q;
	logic [16:0]          dx2_q, dy2_q;

	logic [7:0]           mem [STORE_BYTES];
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [7:0]           mem_wd;

	// circle walk
	logic signed [17:0]   px, py, ax, ay;
	logic                 pon;
	logic signed [12:0]   diam, e1, e2, tx1, ty1;
	logic signed [9:0]    nx, ny;
	logic                 c_done;
	// disc walk
	logic signed [17:0]   fx, fy;
	logic                 f_ok, f_last;

	always_comb begin
		unique case (pt_q)
			3'd0: begin ax = 18'(ox_q);  ay = -18'(oy_q); end
			3'd1: begin ax = 18'(ox_q);  ay = 18'(oy_q);  end
			3'd2: begin ax = -18'(ox_q); ay = -18'(oy_q); end
			3'd3: begin ax = -18'(ox_q); ay = 18'(oy_q);  end
			3'd4: begin ax = 18'(oy_q);  ay = -18'(ox_q); end
			3'd5: begin ax = 18'(oy_q);  ay = 18'(ox_q);  end
			3'd6: begin ax = -18'(oy_q); ay = -18'(ox_q); end
			default: begin ax = -18'(oy_q); ay = 18'(ox_q); end
		endcase
		px  = 18'(cmd_q.cx) + ax;
		py  = 18'(cmd_q.cy) + ay;
		pon = on_screen(px, py);

		diam = 13'(cmd_q.r) <<< 1;
		e1   = (err_q <= 0) ? err_q + ty_q : err_q;
		ny   = (err_q <= 0) ? oy_q + 10'sd1 : oy_q;
		ty1  = (err_q <= 0) ? ty_q + 13'sd2 : ty_q;
		tx1  = (e1 > 0) ? tx_q + 13'sd2 : tx_q;
		nx   = (e1 > 0) ? ox_q - 10'sd1 : ox_q;
		e2   = (e1 > 0) ? e1 + tx1 - diam : e1;
		c_done = (nx < ny);

		fx     = 18'(cmd_q.cx) + 18'(dx_q);
		fy     = 18'(cmd_q.cy) + 18'(dy_q);
		f_ok   = ((18'(dx2_q) + 18'(dy2_q)) <= 18'(cmd_q.rsq)) && on_screen(fx, fy);
		f_last = (dx_q == 10'(cmd_q.r)) && (dy_q == 10'(cmd_q.r));
	end

	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;
	assign init_busy = init_q;
	assign res_push  = (state_q == S_WR) && rd_q && !res_full;
	assign res_data  = rd_off_q ? 4'd0 : (odd_q ? rdata_q[7:4] : rdata_q[3:0]);

	assign mem_we = (state_q == S_CLR) || ((state_q == S_WR) && !rd_q);
	assign mem_wa = (state_q == S_CLR) ? clr_q : addr_q;
	assign mem_wd = (state_q == S_CLR) ? {cmd_q.color, cmd_q.color} :
		(odd_q ? {cmd_q.color, rdata_q[3:0]} : {rdata_q[7:4], cmd_q.color});

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ret_q    <= S_IDLE;
			cmd_q    <= '0;
			clr_q    <= '0;
			addr_q   <= '0;
			odd_q    <= 1'b0;
			rd_q     <= 1'b0;
			rd_off_q <= 1'b0;
			init_q   <= 1'b1;
			rx_q     <= '0;
			ry_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			tx_q     <= '0;
			ty_q     <= '0;
			err_q    <= '0;
			pt_q     <= '0;
			dx2_q    <= '0;
			dy2_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd_in;
						rd_q  <= (cmd_in.op == ACT_READ);
						unique case (cmd_in.op)
							ACT_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							ACT_READ: begin
								addr_q   <= addr_of(cmd_in.cx[XW-1:0], cmd_in.cy[YW-1:0]);
								odd_q    <= cmd_in.cx[0];
								rd_off_q <= !cmd_in.on_scr;
								ret_q    <= S_IDLE;
								state_q  <= S_RD;
							end
							ACT_RECT, ACT_FILL: begin
								rx_q    <= cmd_in.x0;
								ry_q    <= cmd_in.y0;
								state_q <= S_RECT;
							end
							ACT_CIRC: begin
								ox_q    <= 10'(cmd_in.r) - 10'sd1;
								oy_q    <= '0;
								tx_q    <= 13'sd1;
								ty_q    <= 13'sd1;
								err_q   <= 13'sd1 - (13'(cmd_in.r) <<< 1);
								pt_q    <= '0;
								state_q <= S_COUT;
							end
							ACT_DISC: begin
								dx_q    <= -10'(cmd_in.r);
								dy_q    <= -10'(cmd_in.r);
								dx2_q   <= 17'(cmd_in.rsq);
								dy2_q   <= 17'(cmd_in.rsq);
								state_q <= S_CFILL;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RECT: begin
					// every visited pixel is plotted; middle rows of an outline jump from the left to the right edge
					addr_q  <= addr_of(rx_q, ry_q);
					odd_q   <= rx_q[0];
					state_q <= S_RD;
					if (rx_q == cmd_q.x1) begin
						rx_q <= cmd_q.x0;
						ry_q <= ry_q + YW'(1);
						ret_q <= (ry_q == cmd_q.y1) ? S_IDLE : S_RECT;
					end else begin
						ret_q <= S_RECT;
						if (cmd_q.op == ACT_RECT && ry_q != cmd_q.y0 && ry_q != cmd_q.y1
							&& rx_q == cmd_q.x0)
							rx_q <= cmd_q.x1;
						else
							rx_q <= rx_q + XW'(1);
					end
				end
				S_COUT: begin
					addr_q <= addr_of(px[XW-1:0], py[YW-1:0]);
					odd_q  <= px[0];
					pt_q   <= pt_q + 3'd1;
					if (pt_q == 3'd7) begin
						ox_q  <= nx;
						oy_q  <= ny;
						tx_q  <= tx1;
						ty_q  <= ty1;
						err_q <= e2;
					end
					if (pon) begin
						state_q <= S_RD;
						ret_q   <= (pt_q == 3'd7 && c_done) ? S_IDLE : S_COUT;
					end else if (pt_q == 3'd7 && c_done) begin
						state_q <= S_IDLE;
					end
				end
				S_CFILL: begin
					addr_q <= addr_of(fx[XW-1:0], fy[YW-1:0]);
					odd_q  <= fx[0];
					if (dy_q == 10'(cmd_q.r)) begin
						dy_q  <= -10'(cmd_q.r);
						dy2_q <= 17'(cmd_q.rsq);
						dx_q  <= dx_q + 10'sd1;
						dx2_q <= 17'(18'(dx2_q) + (18'(dx_q) <<< 1) + 18'sd1);
					end else begin
						dy_q  <= dy_q + 10'sd1;
						dy2_q <= 17'(18'(dy2_q) + (18'(dy_q) <<< 1) + 18'sd1);
					end
					if (f_ok) begin
						state_q <= S_RD;
						ret_q   <= f_last ? S_IDLE : S_CFILL;
					end else if (f_last) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (!rd_q || !res_full) state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FSR_ASSERT_IMP(a_res_slot, res_push, !res_full, "result pushed into a full slot")
	`FSR_ASSERT_IMP(a_we_state, mem_we, (state_q == S_CLR) || (state_q == S_WR), "stray store write")
	`FSR_ASSERT_NXT(a_rd_then_wr, state_q == S_RD, state_q == S_WR, "read not followed by write-back")
	`FSR_ASSERT_IMP(a_no_pop_init, cmd_pop, !init_q, "command taken during clearing pass")
endmodule
`default_nettype wire

[rtl/core/framebuffer_shape_raster.sv]
// Shape raster over a packed 4-bit framebuffer: pixel read, clear, rectangles, circles.
// Steps: a pixel read result is ready after setup, store read and write back; a drawn pixel
// takes the same steps, a skipped position only setup; clear writes every byte of the store.
// Commands: one at a time in the engine; two more queue in the command FIFO.
// Reset: asynchronous; a clearing pass over all 8192 store bytes runs first with full held high.
// Depends on fsr_pkg, fsr_front, fsr_cmd_fifo, fsr_engine.
`default_nettype none
module framebuffer_shape_raster (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic        [2:0] action,
	input  wire logic       [15:0] corner_left,
	input  wire logic       [15:0] corner_top,
	input  wire logic       [15:0] corner_right,
	input  wire logic       [15:0] corner_bottom,
	input  wire logic signed [15:0] center_x,
	input  wire logic signed [15:0] center_y,
	input  wire logic        [7:0] radius,
	input  wire logic        [3:0] color,
	output logic                   empty,
	input  wire logic              pop,
	output logic             [3:0] pixel_value
);
	import fsr_pkg::*;

	cmd_t       f_cmd, q_cmd;
	logic       keep, q_full, q_empty, q_pop, init_busy;
	logic       res_push;
	logic [3:0] res_data;
	logic       res_valid_q;
	logic [3:0] res_q;

	// classify the incoming item; no-op commands are accepted and dropped
	fsr_front u_front (
		.action, .corner_left, .corner_top, .corner_right, .corner_bottom,
		.center_x, .center_y, .radius, .color,
		.cmd(f_cmd), .keep
	);

	// hold off new items while the queue is full or the store is being cleared
	assign full = q_full || init_busy;

	fsr_cmd_fifo u_fifo (
		.clk, .arst_n,
		.wr_en(push && !full && keep), .wr_cmd(f_cmd), .is_full(q_full),
		.rd_en(q_pop), .rd_cmd(q_cmd), .is_empty(q_empty)
	);

	fsr_engine u_engine (
		.clk, .arst_n,
		.cmd_empty(q_empty), .cmd_in(q_cmd), .cmd_pop(q_pop), .init_busy,
		.res_full(res_valid_q), .res_push, .res_data
	);

	// single result slot; the engine waits on it while it holds an unread item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_push) begin
				res_valid_q <= 1'b1;
				res_q       <= res_data;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !res_valid_q;
	assign pixel_value = res_q;
endmodule
`default_nettype wire
